// ----- hw/rtl/mexp_pkg.sv -----
package mexp_pkg;

   // Default width of the base, exponent, modulus and result.
   localparam int DEFAULT_WIDTH = 32;

   // Modulus value after reset, before any write through the CSR port.
   localparam logic [31:0] RESET_MODULUS = 32'd1000000007;

   // Sequencer states of the exponentiation controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MULT,
      ST_SQUARE,
      ST_DONE
   } mexp_state_type;

endpackage

// ----- hw/rtl/mexp_modmul.sv -----
module mexp_modmul #(
   parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] op_a,
   input  logic [OPERAND_WIDTH-1:0] op_b,
   input  logic [OPERAND_WIDTH:0]   modulus_ext,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] product
);
   import mexp_pkg::*;

   localparam int CW = $clog2(OPERAND_WIDTH + 1);

   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] b_ff, b_in;
   logic [OPERAND_WIDTH-1:0] r_ff, r_in;
   logic [OPERAND_WIDTH:0]   m_ff, m_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     done_ff, done_in;

   logic [OPERAND_WIDTH+1:0] sum;
   logic [OPERAND_WIDTH+2:0] sub1;
   logic [OPERAND_WIDTH+2:0] sub2;
   logic [OPERAND_WIDTH-1:0] r_step;

   // One multiplier bit per cycle, MSB first: r = 2r + bit*a, then bring
   // the sum back below the modulus. With r and a below m the sum stays
   // below 3m, so at most two subtractions are needed; both are tried at once.
   always_comb begin
      sum  = {1'b0, r_ff, 1'b0} + {2'b00, a_ff & {OPERAND_WIDTH{b_ff[OPERAND_WIDTH-1]}}};
      sub1 = {1'b0, sum} - {2'b00, m_ff};
      sub2 = {1'b0, sum} - {1'b0, m_ff, 1'b0};
      if (!sub2[OPERAND_WIDTH+2]) begin
         r_step = sub2[OPERAND_WIDTH-1:0];
      end else if (!sub1[OPERAND_WIDTH+2]) begin
         r_step = sub1[OPERAND_WIDTH-1:0];
      end else begin
         r_step = sum[OPERAND_WIDTH-1:0];
      end
   end

   // Operand capture, multiplier shift register and bit counter.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CW'(1));
      if (start) begin
         a_in   = op_a;
         b_in   = op_b;
         r_in   = '0;
         m_in   = modulus_ext;
         cnt_in = CW'(OPERAND_WIDTH);
      end else if (cnt_ff != '0) begin
         r_in   = r_step;
         b_in   = {b_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
      m_ff <= m_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

   // The partial remainder never reaches the modulus while a product runs.
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> ({1'b0, r_ff} < m_ff))
      else $error("modmul: partial remainder not reduced");

   // A finished product is fully reduced.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, r_ff} < m_ff))
      else $error("modmul: product not reduced");

   // A new product is never started while one is in progress.
   assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0))
      else $error("modmul: start while busy");

endmodule

// ----- hw/rtl/modular_exponentiation_top.sv -----
// Modular exponentiation, right-to-left square-and-multiply, one item at a time.
// Each modular product is computed in the bit-serial multiplier.
// A new request is taken once the previous result is loaded into the output register.
// Synchronous active-high reset clears control state and sets modulus to 1000000007.
module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_base_value,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0] rsp_power_result,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [OPERAND_WIDTH-1:0] csr_modulus
);
   import mexp_pkg::*;

   mexp_state_type           state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] exp_ff, exp_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [OPERAND_WIDTH-1:0] pow_ff, pow_in;
   logic [OPERAND_WIDTH-1:0] modulus_ff, modulus_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic                     mul_start;
   logic [OPERAND_WIDTH-1:0] mul_a;
   logic [OPERAND_WIDTH-1:0] mul_b;
   logic                     mul_done;
   logic [OPERAND_WIDTH-1:0] mul_product;
   logic [OPERAND_WIDTH:0]   modulus_ext;
   logic                     rsp_free;

   // A modulus of zero stands for 2^OPERAND_WIDTH, so products wrap.
   assign modulus_ext = {(modulus_ff == '0), modulus_ff};
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand selection.
   // The base is first reduced as 1 * base so later operands stay below m.
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      mul_a     = pow_ff;
      mul_b     = pow_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_valid;
            mul_a     = OPERAND_WIDTH'(1);
            mul_b     = req_base_value;
         end
         ST_STEP: begin
            mul_start = (exp_ff != '0);
            if (exp_ff[0]) begin
               mul_b = acc_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath updates for exponent, accumulator, power and result register.
   always_comb begin
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      pow_in        = pow_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (state_ff == ST_IDLE && req_valid) begin
         exp_in = req_exponent;
         acc_in = OPERAND_WIDTH'(1);
      end
      if (mul_done && (state_ff == ST_REDUCE || state_ff == ST_SQUARE)) begin
         pow_in = mul_product;
      end
      if (mul_done && state_ff == ST_SQUARE) begin
         exp_in = {1'b0, exp_ff[OPERAND_WIDTH-1:1]};
      end
      if (mul_done && state_ff == ST_MULT) begin
         acc_in    = mul_product;
         exp_in[0] = 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_result_in = acc_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   // Modulus register; a transfer is taken in any cycle.
   assign csr_ready  = 1'b1;
   assign modulus_in = csr_valid ? csr_modulus : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= RESET_MODULUS[OPERAND_WIDTH-1:0];
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
      exp_ff        <= exp_in;
      acc_ff        <= acc_in;
      pow_ff        <= pow_in;
      rsp_result_ff <= rsp_result_in;
   end

   mexp_modmul #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_modmul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .modulus_ext(modulus_ext),
      .done       (mul_done),
      .product    (mul_product)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule

// ----- dv/modular_exponentiation_top_tb.sv -----
`timescale 1ns / 100ps

module modular_exponentiation_top_tb;

   import mexp_pkg::*;

   localparam int W = DEFAULT_WIDTH;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD_CYCLES = 12_000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES = 2_300;
   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 36;
   localparam int DIRECTED_COUNT = 23;
   localparam logic [W-1:0] ALL_ONES = '1;

   // One directed row: an optional modulus write, the operands, and a typed result.
   typedef struct packed {
      logic         write_modulus;
      logic [W-1:0] modulus;
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      logic         typed;
      logic [W-1:0] power;
   } directed_row_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [W-1:0] req_base_value = '0;
   logic [W-1:0] req_exponent = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [W-1:0] rsp_power_result;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [W-1:0] csr_modulus = '0;

   logic [W-1:0] expected_powers [$];
   logic [W-1:0] modulus_setting = RESET_MODULUS;
   logic         burst_mode = 1'b0;
   logic         long_hold_request = 1'b0;
   int           error_count = 0;
   int           requests_sent = 0;
   int           results_checked = 0;
   int           modulus_writes = 0;
   int           cycle_count = 0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Reset modulus: zero exponents, zero and unit bases, unreduced base.
      '{1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'hFFFFFFFF, 32'h0, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'h0, 32'd5, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'd1, 32'hFFFFFFFF, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'd2, 32'd10, 1'b1, 32'd1024},
      '{1'b0, 32'h0, 32'hFFFFFFFF, 32'd1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'd1000000007, 32'd3, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'd3, 32'h80000000, 1'b0, 32'h0},
      // Modulus of one: a zero exponent still gives one, anything else zero.
      '{1'b1, 32'd1, 32'd5, 32'h0, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'd5, 32'd3, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
      // Modulus of zero: products wrap to the operand width.
      '{1'b1, 32'd0, 32'd2, 32'd31, 1'b1, 32'h80000000},
      '{1'b0, 32'h0, 32'd2, 32'd32, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'hFFFFFFFF, 32'd2, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'd3, 32'hFFFFFFFF, 1'b0, 32'h0},
      // Largest modulus.
      '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'd2, 32'd32, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'hFFFFFFFE, 32'd2, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0},
      // Smallest nontrivial modulus.
      '{1'b1, 32'd2, 32'd7, 32'd5, 1'b1, 32'd1},
      '{1'b0, 32'h0, 32'd8, 32'd1, 1'b1, 32'd0},
      '{1'b0, 32'h0, 32'd0, 32'd0, 1'b1, 32'd1}
   };

   modular_exponentiation_top #(
      .OPERAND_WIDTH(W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base_value(req_base_value),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_result(rsp_power_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_modulus(csr_modulus)
   );

   // Free-running 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reduce a double-width product; a zero modulus stands for 2^W.
   function automatic logic [2*W-1:0] reduce_product(input logic [2*W-1:0] product,
                                                     input logic [W-1:0] modulus);
      if (modulus == '0) begin
         return {{W{1'b0}}, product[W-1:0]};
      end
      return product % {{W{1'b0}}, modulus};
   endfunction

   // Right-to-left square-and-multiply over the exponent bits.
   function automatic logic [W-1:0] modpow_expected(input logic [W-1:0] base,
                                                    input logic [W-1:0] exponent,
                                                    input logic [W-1:0] modulus);
      logic [2*W-1:0] power;
      logic [2*W-1:0] acc;
      logic [W-1:0]   bits;
      power = {{W{1'b0}}, base};
      acc = (2*W)'(1);
      bits = exponent;
      while (bits != '0) begin
         if (bits[0]) begin
            acc = reduce_product(acc * power, modulus);
         end
         power = reduce_product(power * power, modulus);
         bits = bits >> 1;
      end
      return acc[W-1:0];
   endfunction

   task automatic flag_error(input string message);
      $display("ERROR at cycle %0d: %s", cycle_count, message);
      error_count++;
   endtask

   // Offer one request after a random gap and record its expected power on transfer.
   task automatic send_request(input logic [W-1:0] base, input logic [W-1:0] exponent,
                               input logic typed, input logic [W-1:0] typed_power);
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base_value <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_powers.push_back(typed ? typed_power
                                      : modpow_expected(base, exponent, modulus_setting));
      requests_sent++;
   endtask

   // Let the block go idle, then write a new modulus.
   task automatic write_modulus(input logic [W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      modulus_setting = value;
      modulus_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result receiver: random stalls, with one long hold-off on request.
   initial begin
      int unsigned hold;
      wait (!reset);
      @(negedge clock);
      rsp_ready <= 1'b1;
      forever begin
         if (long_hold_request) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end else begin
            hold = burst_mode ? 0 : $urandom_range(0, 8);
         end
         if (hold != 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare every result transfer with the oldest expected power.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_powers.size() == 0) begin
            flag_error($sformatf("result 0x%08h with no request outstanding",
                                 rsp_power_result));
         end else begin
            if (rsp_power_result !== expected_powers[0]) begin
               flag_error($sformatf("power_result 0x%08h, expected 0x%08h",
                                    rsp_power_result, expected_powers[0]));
            end
            void'(expected_powers.pop_front());
            results_checked++;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_powers.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, then random phases under several moduli.
   initial begin
      logic [W-1:0] phase_moduli [RANDOM_PHASES];
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (directed_rows[i].write_modulus) begin
            write_modulus(directed_rows[i].modulus);
         end
         send_request(directed_rows[i].base, directed_rows[i].exponent,
                      directed_rows[i].typed, directed_rows[i].power);
      end

      phase_moduli[0] = RESET_MODULUS;
      phase_moduli[1] = $urandom | 32'h80000000;
      phase_moduli[2] = $urandom_range(2, 1000);
      phase_moduli[3] = ALL_ONES;
      phase_moduli[4] = 1;
      phase_moduli[5] = 0;
      phase_moduli[6] = $urandom;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_modulus(phase_moduli[phase]);
         burst_mode = (phase == 2 || phase == 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Many full-width operands, with small, sparse and extreme values mixed in.
            case ($urandom_range(0, 9))
               6:       exponent = '0;
               4, 5:    exponent = $urandom_range(1, 64);
               7:       exponent = 1 << $urandom_range(0, W - 1);
               8:       exponent = ALL_ONES;
               9:       exponent = $urandom_range(0, 255);
               default: exponent = $urandom;
            endcase
            case ($urandom_range(0, 9))
               6:       base = '0;
               7:       base = 1;
               8:       base = ALL_ONES;
               9:       base = modulus_setting + $urandom_range(0, 3) - 1;
               default: base = $urandom;
            endcase
            // Hold off the receiver for a long stretch so the block backs up.
            if (phase == 1 && n == 4) begin
               long_hold_request = 1'b1;
            end
            send_request(base, exponent, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d requests under %0d modulus writes,",
               results_checked, requests_sent, modulus_writes);
      $display("covering moduli 0, 1, 2, all ones and random, plus a long result stall.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
